@@ rtl/core/tccs_pkg.sv @@
package tccs_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Field widths of the channels.
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int RA_W   = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Store addressing and the width of the shared adder.
  localparam int ADDR_W = $clog2(CELLS);
  localparam int UW     = (ADDR_W + 1 > RA_W) ? ADDR_W + 1 : RA_W;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  // First cell of the last row, where the upward copy of a scroll ends.
  localparam int SCROLL_END = (ROWS - 1) * COLUMNS;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam int                TAB_STEP     = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Operands of the shared add and compare unit.
  typedef struct packed {
    logic [UW-1:0] a;
    logic [UW-1:0] b;
    logic [UW-1:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic [UW-1:0] sum;
    logic          ge;
  } alu_rsp_t;

  // One write port and one read port of the screen store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/core/tccs_in_if.sv @@
interface tccs_in_if;
  import tccs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] attribute;
  logic [RA_W-1:0]   read_address;

  modport source (output valid, output opcode, output char_code, output attribute,
                  output read_address, input ready);
  modport sink (input valid, input opcode, input char_code, input attribute,
                input read_address, output ready);
endinterface

@@ rtl/core/tccs_out_if.sv @@
interface tccs_out_if;
  import tccs_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] read_data;
  logic              did_scroll;

  modport source (output valid, output cursor_position, output read_data,
                  output did_scroll, input ready);
  modport sink (input valid, input cursor_position, input read_data,
                input did_scroll, output ready);
endinterface

@@ rtl/core/tccs_alu.sv @@
module tccs_alu (
  input  tccs_pkg::alu_req_t req,
  output tccs_pkg::alu_rsp_t rsp
);
  import tccs_pkg::*;

  always_comb begin
    rsp.sum = req.a + req.b;
    rsp.ge  = (rsp.sum >= req.lim);
  end
endmodule

@@ rtl/core/tccs_store.sv @@
module tccs_store (
  input  logic                          clk,
  input  tccs_pkg::mem_req_t            req,
  output logic [tccs_pkg::CELL_W-1:0]   rdata
);
  import tccs_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end
endmodule

@@ rtl/core/text_console_cursor_scroll_top.sv @@
// Channel  Direction  Contents
// cmd      in         opcode, char_code, attribute, read_address
// rsp      out        cursor_position, read_data, did_scroll
//
// After reset the store is cleared one cell a cycle, all CELLS cells, with cmd not ready.
// A put passes S_PUT, then S_ROWADV if the row advances, then S_POS; a read S_RD, S_RDW, S_POS; a clear S_CLR, S_POS.
// A put that scrolls copies each of the (ROWS-1)*COLUMNS cells through the single store read port,
// reading in S_SC_RD and writing in S_SC_WR, then blanks the last row one cell a cycle.
// All address arithmetic goes through one shared adder; cmd is taken only when the block is idle.
// A waiting result does not block the next word; a stalled rsp holds only the final step.
module text_console_cursor_scroll_top (
  input logic       clk,
  input logic       rst,
  tccs_in_if.sink   cmd,
  tccs_out_if.source rsp
);
  import tccs_pkg::*;

  typedef enum logic [10:0] {
    S_INIT   = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_PUT    = 11'b000_0000_0100,
    S_ROWADV = 11'b000_0000_1000,
    S_SC_RD  = 11'b000_0001_0000,
    S_SC_WR  = 11'b000_0010_0000,
    S_FILL   = 11'b000_0100_0000,
    S_CLR    = 11'b000_1000_0000,
    S_RD     = 11'b001_0000_0000,
    S_RDW    = 11'b010_0000_0000,
    S_POS    = 11'b100_0000_0000
  } state_t;

  state_t            state;
  logic [UW-1:0]     ptr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [UW-1:0]     row_base;
  logic [CHAR_W-1:0] ch_r;
  logic [ATTR_W-1:0] attr_r;
  logic [RA_W-1:0]   addr_r;
  logic              rd_ok;
  logic [CELL_W-1:0] data_r;
  logic              scr_r;

  logic              out_valid;
  logic [POS_W-1:0]  out_pos;
  logic [CELL_W-1:0] out_data;
  logic              out_scroll;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  mem_req_t          mem_req;
  logic [CELL_W-1:0] rdata;

  logic [CELL_W-1:0] blank;
  logic              is_nl, is_cr, is_tab, is_bs, printable;
  logic [COL_W:0]    col_e, col_x;
  logic              wrap, row_adv;
  logic [COL_W-1:0]  col_new;

  tccs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  tccs_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign blank = {attr_r, BLANK_CHAR};

  // Cursor effect of a put, worked out on the narrow column and row.
  always_comb begin
    is_nl     = (ch_r == CH_NEWLINE);
    is_cr     = (ch_r == CH_RETURN);
    is_tab    = (ch_r == CH_TAB);
    is_bs     = (ch_r == CH_BACKSPACE);
    printable = !(is_nl || is_cr || is_tab || is_bs);
    col_e     = {1'b0, col};
    if (is_nl || is_cr) begin
      col_x = '0;
    end else if (is_tab) begin
      col_x = (col_e + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
    end else if (is_bs) begin
      col_x = (col != '0) ? col_e - (COL_W+1)'(1) : col_e;
    end else begin
      col_x = col_e + (COL_W+1)'(1);
    end
    wrap    = (col_x >= (COL_W+1)'(COLUMNS));
    row_adv = is_nl || wrap;
    col_new = wrap ? '0 : col_x[COL_W-1:0];
  end

  always_comb begin
    alu_req.a   = ptr;
    alu_req.b   = UW'(1);
    alu_req.lim = UW'(CELLS);
    case (state)
      S_PUT, S_POS: begin
        alu_req.a = row_base;
        alu_req.b = UW'(col);
      end
      S_ROWADV: begin
        alu_req.a = row_base;
        alu_req.b = UW'(COLUMNS);
      end
      S_SC_RD: begin
        alu_req.b = UW'(COLUMNS);
      end
      S_SC_WR: begin
        alu_req.lim = UW'(SCROLL_END);
      end
      S_RD: begin
        alu_req.a = UW'(addr_r);
        alu_req.b = '0;
      end
      default: begin
        alu_req.a = ptr;
      end
    endcase
  end

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = ptr[ADDR_W-1:0];
    mem_req.wdata = '0;
    mem_req.raddr = alu_rsp.sum[ADDR_W-1:0];
    case (state)
      S_INIT: begin
        mem_req.we = 1'b1;
      end
      S_PUT: begin
        mem_req.we    = printable;
        mem_req.waddr = alu_rsp.sum[ADDR_W-1:0];
        mem_req.wdata = {attr_r, ch_r};
      end
      S_SC_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = rdata;
      end
      S_FILL, S_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = blank;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ptr       <= '0;
      col       <= '0;
      row       <= '0;
      row_base  <= '0;
      out_valid <= 1'b0;
    end else begin
      // In S_POS the output register is refilled below, so it is only emptied elsewhere.
      if (out_valid && rsp.ready && state != S_POS) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          ptr <= alu_rsp.sum;
          if (alu_rsp.ge) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            ch_r   <= cmd.char_code;
            attr_r <= cmd.attribute;
            addr_r <= cmd.read_address;
            data_r <= '0;
            scr_r  <= 1'b0;
            ptr    <= '0;
            case (op_t'(cmd.opcode))
              OP_PUT:   state <= S_PUT;
              OP_CLEAR: state <= S_CLR;
              OP_READ:  state <= S_RD;
              default:  state <= S_POS;
            endcase
          end
        end
        S_PUT: begin
          col <= col_new;
          if (!row_adv) begin
            state <= S_POS;
          end else if (row == ROW_W'(ROWS - 1)) begin
            // Passing the last row: the cursor stays there and the screen moves up.
            scr_r <= 1'b1;
            ptr   <= '0;
            state <= S_SC_RD;
          end else begin
            row   <= row + ROW_W'(1);
            state <= S_ROWADV;
          end
        end
        S_ROWADV: begin
          row_base <= alu_rsp.sum;
          state    <= S_POS;
        end
        S_SC_RD: begin
          state <= S_SC_WR;
        end
        S_SC_WR: begin
          ptr   <= alu_rsp.sum;
          state <= alu_rsp.ge ? S_FILL : S_SC_RD;
        end
        S_FILL: begin
          ptr <= alu_rsp.sum;
          if (alu_rsp.ge) begin
            state <= S_POS;
          end
        end
        S_CLR: begin
          ptr <= alu_rsp.sum;
          if (alu_rsp.ge) begin
            col      <= '0;
            row      <= '0;
            row_base <= '0;
            state    <= S_POS;
          end
        end
        S_RD: begin
          rd_ok <= !alu_rsp.ge;
          state <= S_RDW;
        end
        S_RDW: begin
          data_r <= rd_ok ? rdata : '0;
          state  <= S_POS;
        end
        S_POS: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_pos    <= POS_W'(alu_rsp.sum);
            out_data   <= data_r;
            out_scroll <= scr_r;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.ready           = (state == S_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.cursor_position = out_pos;
  assign rsp.read_data       = out_data;
  assign rsp.did_scroll      = out_scroll;

endmodule

@@ rtl/core/tccs_checker.sv @@
module tccs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [tccs_pkg::POS_W-1:0]  cursor_position,
  input logic [tccs_pkg::CELL_W-1:0] read_data,
  input logic                        did_scroll
);
  import tccs_pkg::*;

  localparam logic POS_EXACT = (CELLS <= 2048);

  // Reset starts the clearing pass, so no word may be taken right after it.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("cmd ready right after reset");

  // Every word keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("cmd ready in the cycle after an accepted word");

  // A scroll always leaves the cursor on the last row.
  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && did_scroll |-> (!POS_EXACT || cursor_position >= POS_W'(SCROLL_END)))
    else $error("scroll reported with the cursor above the last row");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(cursor_position) && $stable(read_data) && $stable(did_scroll))
    else $error("rsp word changed while stalled");

endmodule

bind text_console_cursor_scroll_top tccs_checker u_tccs_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .cursor_position (rsp.cursor_position),
  .read_data       (rsp.read_data),
  .did_scroll      (rsp.did_scroll)
);
